>>> src/cal_pkg.sv
// Shared constants, codes and controller/datapath types for the cursor list.
`timescale 1ns / 1ps

package cal_pkg;

   localparam int CAPACITY   = 1024;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   // Fixed field widths of the channels
   localparam int REQ_TYPE_W = 4;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 10;
   localparam int STATUS_W   = 2;
   localparam int OUT_DATA_W = 32;
   localparam int COUNT_W    = 11;
   localparam int CURSOR_W   = 10;

   // Width for comparing a position against the element count
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_INS_AFTER  = 4'd0,
      OP_INS_BEFORE = 4'd1,
      OP_DELETE     = 4'd2,
      OP_PREV       = 4'd3,
      OP_NEXT       = 4'd4,
      OP_FIRST      = 4'd5,
      OP_LAST       = 4'd6,
      OP_READ       = 4'd7,
      OP_WRITE      = 4'd8
   } cal_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } cal_status_type;

   // Controller to datapath
   typedef struct packed {
      logic           load;       // latch request fields, clear result
      logic           set_err;    // record error status
      cal_status_type err_code;
      logic           start_up;   // open a gap for an insertion
      logic           start_down; // close the gap left by a delete
      logic           commit;     // apply the request to store and pointers
      logic           fetch;      // read the element the result reports
      logic           load_rsp;   // move the result into the output register
   } cal_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_insert;
      logic is_delete;
      logic is_move;
      logic is_index;
      logic needs_fetch;
      logic empty;
      logic full;
      logic pos_ok;
      logic del_last;
      logic shift_busy;
      logic rsp_free;
   } cal_stat_type;

endpackage

>>> src/cal_req_if.sv
// Request channel: valid/ready handshake with request payload.
`timescale 1ns / 1ps

interface cal_req_if;
   import cal_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [VALUE_W-1:0]    value;
   logic [POS_W-1:0]      position;

   modport source (output valid, req_type, value, position, input ready);
   modport sink   (input valid, req_type, value, position, output ready);
endinterface

>>> src/cal_rsp_if.sv
// Response channel: valid/ready handshake with result payload.
`timescale 1ns / 1ps

interface cal_rsp_if;
   import cal_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic                  moved;
   logic [OUT_DATA_W-1:0] data;
   logic [COUNT_W-1:0]    count;
   logic [CURSOR_W-1:0]   cursor;

   modport source (output valid, status, moved, data, count, cursor, input ready);
   modport sink   (input valid, status, moved, data, count, cursor, output ready);
endinterface

>>> src/cal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> src/cal_ctrl.sv
// Request sequencer: decodes checks, runs shifts, commit, fetch and response.
`timescale 1ns / 1ps

module cal_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cal_pkg::cal_stat_type st,
   output cal_pkg::cal_cmd_type  cmd
);
   import cal_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_SHIFT  = 7'b0000100,
      S_COMMIT = 7'b0001000,
      S_FETCH  = 7'b0010000,
      S_WAIT   = 7'b0100000,
      S_RESP   = 7'b1000000
   } cal_state_type;

   cal_state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.err_code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (st.is_insert) begin
               if (st.full) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_FULL;
                  state_in     = S_RESP;
               end else if (!st.empty) begin
                  cmd.start_up = 1'b1;
                  state_in     = S_SHIFT;
               end else begin
                  state_in = S_COMMIT;
               end
            end else if (st.is_delete) begin
               if (st.empty) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_EMPTY;
                  state_in     = S_RESP;
               end else if (st.del_last) begin
                  state_in = S_COMMIT;
               end else begin
                  cmd.start_down = 1'b1;
                  state_in       = S_SHIFT;
               end
            end else if (st.is_move) begin
               if (st.empty) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_EMPTY;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_COMMIT;
               end
            end else if (st.is_index) begin
               if (!st.pos_ok) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_RANGE;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_COMMIT;
               end
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_SHIFT: begin
            if (!st.shift_busy) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = st.needs_fetch ? S_FETCH : S_RESP;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            // read data lands this cycle and holds until the next read
            state_in = S_RESP;
         end
         S_RESP: begin
            if (st.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> st.rsp_free)
      else $error("response loaded into an occupied output register");

   a_commit_after_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !st.shift_busy)
      else $error("commit while shift still in flight");

   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_DECODE))
      else $error("accepted item did not reach decode");

endmodule

>>> src/cal_dpath.sv
// List datapath: element RAM, count and cursor, shift pipeline, result register.
`timescale 1ns / 1ps

module cal_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  cal_pkg::cal_cmd_type             cmd,
   output cal_pkg::cal_stat_type            st,
   input  logic [cal_pkg::REQ_TYPE_W-1:0]   req_type,
   input  logic [cal_pkg::VALUE_W-1:0]      value,
   input  logic [cal_pkg::POS_W-1:0]        position,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [cal_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_moved,
   output logic [cal_pkg::OUT_DATA_W-1:0]   rsp_data,
   output logic [cal_pkg::COUNT_W-1:0]      rsp_count,
   output logic [cal_pkg::CURSOR_W-1:0]     rsp_cursor
);
   import cal_pkg::*;

   // latched request
   cal_op_type            op_ff, op_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [POS_W-1:0]      pos_ff, pos_in;

   // list pointers
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;

   // shift pipeline
   logic [CNT_W-1:0]  mv_cnt_ff, mv_cnt_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              dir_up_ff, dir_up_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;

   // pending result
   cal_status_type        res_status_ff, res_status_in;
   logic                  res_moved_ff, res_moved_in;
   logic [DATA_WIDTH-1:0] res_data_ff, res_data_in;
   logic                  res_from_ram_ff, res_from_ram_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_moved_ff, rsp_moved_in;
   logic [OUT_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [CURSOR_W-1:0]   rsp_cursor_ff, rsp_cursor_in;

   // RAM port
   logic                  ram_we, ram_re;
   logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_q;

   logic [CNT_W-1:0] cur_ext, cur_inc, gap;
   logic             is_empty, del_last, has_next;

   cal_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   assign cur_ext  = CNT_W'(cur_ff);
   assign cur_inc  = cur_ext + CNT_W'(1);
   assign is_empty = (len_ff == '0);
   assign del_last = (cur_ff != '0) && (cur_inc == len_ff);
   assign has_next = (cur_inc < len_ff);
   assign gap      = (op_ff == OP_INS_AFTER) ? cur_inc : cur_ext;

   always_comb begin
      st.is_insert   = (op_ff == OP_INS_AFTER) || (op_ff == OP_INS_BEFORE);
      st.is_delete   = (op_ff == OP_DELETE);
      st.is_move     = (op_ff == OP_PREV) || (op_ff == OP_NEXT) ||
                       (op_ff == OP_FIRST) || (op_ff == OP_LAST);
      st.is_index    = (op_ff == OP_READ) || (op_ff == OP_WRITE);
      st.needs_fetch = st.is_delete || st.is_move || (op_ff == OP_READ);
      st.empty       = is_empty;
      st.full        = (len_ff == CNT_W'(CAPACITY));
      st.pos_ok      = (CMP_W'(pos_ff) < CMP_W'(len_ff));
      st.del_last    = del_last;
      st.shift_busy  = (mv_cnt_ff != '0) || wb_valid_ff;
      st.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_in           = op_ff;
      val_in          = val_ff;
      pos_in          = pos_ff;
      len_in          = len_ff;
      cur_in          = cur_ff;
      mv_cnt_in       = mv_cnt_ff;
      rd_addr_in      = rd_addr_ff;
      dir_up_in       = dir_up_ff;
      wb_valid_in     = 1'b0;
      wb_addr_in      = wb_addr_ff;
      res_status_in   = res_status_ff;
      res_moved_in    = res_moved_ff;
      res_data_in     = res_data_ff;
      res_from_ram_in = res_from_ram_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_moved_in    = rsp_moved_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      ram_we          = 1'b0;
      ram_waddr       = wb_addr_ff;
      ram_wdata       = ram_q;
      ram_re          = 1'b0;
      ram_raddr       = rd_addr_ff;

      // shift: read one element a cycle, write it back one slot over next cycle
      if (mv_cnt_ff != '0) begin
         ram_re      = 1'b1;
         wb_valid_in = 1'b1;
         wb_addr_in  = dir_up_ff ? rd_addr_ff + ADDR_W'(1) : rd_addr_ff - ADDR_W'(1);
         rd_addr_in  = dir_up_ff ? rd_addr_ff - ADDR_W'(1) : rd_addr_ff + ADDR_W'(1);
         mv_cnt_in   = mv_cnt_ff - CNT_W'(1);
      end
      if (wb_valid_ff) begin
         ram_we = 1'b1;
      end

      if (cmd.load) begin
         op_in           = cal_op_type'(req_type);
         val_in          = DATA_WIDTH'(value);
         pos_in          = position;
         res_status_in   = ST_OK;
         res_moved_in    = 1'b0;
         res_data_in     = '0;
         res_from_ram_in = 1'b0;
      end

      if (cmd.set_err) begin
         res_status_in = cmd.err_code;
      end

      if (cmd.start_up) begin
         mv_cnt_in  = len_ff - gap;
         rd_addr_in = ADDR_W'(len_ff - CNT_W'(1));
         dir_up_in  = 1'b1;
      end

      if (cmd.start_down) begin
         mv_cnt_in  = len_ff - cur_inc;
         rd_addr_in = cur_ff + ADDR_W'(1);
         dir_up_in  = 1'b0;
      end

      if (cmd.commit) begin
         unique case (op_ff)
            OP_INS_AFTER: begin
               ram_we      = 1'b1;
               ram_waddr   = is_empty ? '0 : cur_ff + ADDR_W'(1);
               ram_wdata   = val_ff;
               len_in      = len_ff + CNT_W'(1);
               res_data_in = val_ff;
            end
            OP_INS_BEFORE: begin
               ram_we      = 1'b1;
               ram_waddr   = cur_ff;
               ram_wdata   = val_ff;
               len_in      = len_ff + CNT_W'(1);
               cur_in      = is_empty ? '0 : cur_ff + ADDR_W'(1);
               res_data_in = val_ff;
            end
            OP_DELETE: begin
               len_in          = len_ff - CNT_W'(1);
               res_from_ram_in = 1'b1;
               if (del_last) begin
                  cur_in = cur_ff - ADDR_W'(1);
               end
            end
            OP_PREV: begin
               res_from_ram_in = 1'b1;
               if (cur_ff != '0) begin
                  cur_in       = cur_ff - ADDR_W'(1);
                  res_moved_in = 1'b1;
               end
            end
            OP_NEXT: begin
               res_from_ram_in = 1'b1;
               if (has_next) begin
                  cur_in       = cur_ff + ADDR_W'(1);
                  res_moved_in = 1'b1;
               end
            end
            OP_FIRST: begin
               cur_in          = '0;
               res_from_ram_in = 1'b1;
            end
            OP_LAST: begin
               cur_in          = ADDR_W'(len_ff - CNT_W'(1));
               res_from_ram_in = 1'b1;
            end
            OP_READ: begin
               res_from_ram_in = 1'b1;
            end
            OP_WRITE: begin
               ram_we      = 1'b1;
               ram_waddr   = ADDR_W'(pos_ff);
               ram_wdata   = val_ff;
               res_data_in = val_ff;
            end
            default: begin
            end
         endcase
      end

      if (cmd.fetch) begin
         ram_re    = 1'b1;
         ram_raddr = (op_ff == OP_READ) ? ADDR_W'(pos_ff) : cur_ff;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_moved_in  = res_moved_ff;
         rsp_data_in   = res_from_ram_ff ? OUT_DATA_W'(ram_q) : OUT_DATA_W'(res_data_ff);
         rsp_count_in  = COUNT_W'(len_ff);
         rsp_cursor_in = CURSOR_W'(cur_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         cur_ff       <= '0;
         mv_cnt_ff    <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         mv_cnt_ff    <= mv_cnt_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      val_ff          <= val_in;
      pos_ff          <= pos_in;
      rd_addr_ff      <= rd_addr_in;
      dir_up_ff       <= dir_up_in;
      wb_addr_ff      <= wb_addr_in;
      res_status_ff   <= res_status_in;
      res_moved_ff    <= res_moved_in;
      res_data_ff     <= res_data_in;
      res_from_ram_ff <= res_from_ram_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_moved_ff    <= rsp_moved_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_cursor_ff   <= rsp_cursor_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_moved  = rsp_moved_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_cursor = rsp_cursor_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("shift read and write hit the same slot");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (cur_ext < len_ff))
      else $error("cursor past last element");

   a_cursor_zero_empty: assert property (@(posedge clock) disable iff (reset)
      (len_ff == '0) |-> (cur_ff == '0))
      else $error("cursor nonzero on empty list");

endmodule

>>> src/cursor_array_list_core.sv
// Top level of the array-backed cursor list.
`timescale 1ns / 1ps

// Channel    Dir  Handshake     Payload
// req_chan   in   valid/ready   req_type[3:0] value[31:0] position[9:0]
// rsp_chan   out  valid/ready   status[1:0] moved data[31:0] count[10:0] cursor[9:0]
//
// One item in flight. An insert shifts n = L - g elements (L = count, g = gap
// slot; none into an empty list), a delete n = L - cursor - 1 (none for a tail
// pullback); deletes, moves and indexed reads then fetch an element, and refusals
// go straight to the response. The shift moves one element per cycle through the
// single port pair of the element RAM; the next item is taken once the result
// is loaded into the output register.
// Reset (synchronous) empties the list and zeroes the cursor; the store is not
// cleared. A result sits in the output register while the next item is taken;
// that item stalls only at its own response step until the register frees.

module cursor_array_list_core (
   input  logic     clock,
   input  logic     reset,
   cal_req_if.sink   req_chan,
   cal_rsp_if.source rsp_chan
);
   import cal_pkg::*;

   cal_cmd_type  cmd;
   cal_stat_type st;
   logic         req_ready;

   // sequencer
   cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // store, pointers, result register
   cal_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_type   (req_chan.req_type),
      .value      (req_chan.value),
      .position   (req_chan.position),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_status (rsp_chan.status),
      .rsp_moved  (rsp_chan.moved),
      .rsp_data   (rsp_chan.data),
      .rsp_count  (rsp_chan.count),
      .rsp_cursor (rsp_chan.cursor)
   );

endmodule
